/* design/ffra_pkg.sv */
// shared types, codes and helpers for the first-fit range allocator
package ffra_pkg;

  localparam logic [32:0] CAP_MAX = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } alloc_status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHK, S_ARD, S_AEV1, S_AEV2, S_RRD, S_REV,
    S_RDEC, S_SRD, S_SWR, S_FIN, S_LST, S_LRD, S_LEV, S_OUT
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_CHK, OP_ARD, OP_AEV1, OP_AEV2, OP_RRD,
    OP_REV, OP_RDEC, OP_SRD, OP_SWR, OP_FIN, OP_LST, OP_LRD, OP_LEV
  } dp_op_e;

  typedef struct packed {
    logic is_rel;
    logic bad;
    logic scan_end;
    logic fit;
    logic shift;
    logic lt;
    logic shift_done;
  } dp_status_t;

  function automatic logic [32:0] sat33(input logic [33:0] s);
    sat33 = s[33] ? '1 : s[32:0];
  endfunction

endpackage

/* design/ffra_dp.sv */
// datapath: range table memory, scan and shift indices, result registers
module ffra_dp import ffra_pkg::*; #(
  parameter int MAX_RANGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_op_e      op_i,
  output dp_status_t  status_o,
  input  logic        cfg_we_i,
  input  logic [32:0] cfg_wdata_i,
  input  logic        in_cmd_i,
  input  logic [32:0] in_size_i,
  input  logic [4:0]  in_lg_i,
  input  logic [31:0] in_off_i,
  output logic [1:0]  res_status_o,
  output logic [31:0] res_offset_o,
  output logic [32:0] res_used_o,
  output logic [32:0] res_largest_o
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);

  logic [64:0] mem [MAX_RANGES];
  logic [64:0] rd_q;

  logic [32:0] cap_q, used_q;
  logic [CW-1:0] cnt_q;

  logic        cmd_q;
  logic [32:0] size_q;
  logic [4:0]  lg_q;
  logic [31:0] off_q;
  logic [CW-1:0] k_q, j_q, pos_q;
  logic        ins_q;
  logic [64:0] ins_ent_q;
  logic [31:0] st_q, pst_q;
  logic [32:0] len_q, plen_q, al_q, max_q;
  logic [33:0] end_q;
  logic [1:0]  res_q;
  logic [31:0] grant_q;

  logic [31:0] rd_st, mask32;
  logic [32:0] rd_len, al_w, pad, cap_sat, left_len, both_len, right_len, used_add, used_sub;
  logic [33:0] end_w, avail, tail_off, post_len, rel_end;
  logic        fit, pad0, post0, full, jl, jr, a_shift, r_shift, bad;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [64:0] wdata;

  assign rd_st  = rd_q[64:33];
  assign rd_len = rd_q[32:0];
  assign mask32 = (32'd1 << lg_q) - 32'd1;
  assign al_w   = ({1'b0, rd_st} + {1'b0, mask32}) & ~{1'b0, mask32};
  assign end_w  = {2'b0, rd_st} + {1'b0, rd_len};

  assign pad      = al_q - {1'b0, st_q};
  assign avail    = end_q - {1'b0, al_q};
  assign fit      = ({1'b0, al_q} < end_q) && ({1'b0, size_q} <= avail);
  assign tail_off = {1'b0, al_q} + {1'b0, size_q};
  assign post_len = end_q - tail_off;
  assign pad0     = (pad == '0);
  assign post0    = (post_len == '0);
  assign full     = (cnt_q == MaxCnt);
  assign a_shift  = fit && ((pad0 && post0) || (!pad0 && !post0 && !full));

  assign rel_end   = {1'b0, off_q} + {1'b0, size_q};
  assign jr        = (k_q != cnt_q) && (rel_end == {2'b0, st_q});
  assign jl        = (k_q != '0) && (({2'b0, pst_q} + {1'b0, plen_q}) == {2'b0, off_q});
  assign r_shift   = (jl && jr) || (!jl && !jr && !full);
  assign left_len  = sat33({1'b0, plen_q} + {1'b0, size_q});
  assign both_len  = sat33({1'b0, left_len} + {1'b0, len_q});
  assign right_len = sat33({1'b0, len_q} + {1'b0, size_q});
  assign used_add  = sat33({1'b0, used_q} + {1'b0, size_q});
  assign used_sub  = (used_q > size_q) ? used_q - size_q : '0;
  assign cap_sat   = (cfg_wdata_i > CAP_MAX) ? CAP_MAX : cfg_wdata_i;

  assign bad = cmd_q ? ((size_q == '0) || (rel_end > {1'b0, cap_q}))
                     : ((size_q == '0) || (size_q > cap_q));

  always_comb begin
    status_o.is_rel     = cmd_q;
    status_o.bad        = bad;
    status_o.scan_end   = (k_q == cnt_q);
    status_o.fit        = fit;
    status_o.shift      = (op_i == OP_AEV2) ? a_shift : r_shift;
    status_o.lt         = rd_st < off_q;
    status_o.shift_done = ins_q ? (j_q == pos_q)
                                : (({1'b0, j_q} + 1'b1) >= {1'b0, cnt_q});
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = k_q[AW-1:0];
    if (cfg_we_i) begin
      we    = 1'b1;
      wdata = {32'd0, cap_sat};
    end else begin
      unique case (op_i)
        OP_INIT: begin
          we    = 1'b1;
          wdata = {32'd0, cap_q};
        end
        OP_AEV2: begin
          we    = fit && !(pad0 && post0) && !(!pad0 && !post0 && full);
          waddr = k_q[AW-1:0];
          wdata = pad0 ? {tail_off[31:0], post_len[32:0]} : {st_q, pad};
        end
        OP_RDEC: begin
          we    = jl || jr;
          waddr = jl ? AW'(k_q - 1'b1) : k_q[AW-1:0];
          wdata = (jl && jr) ? {pst_q, both_len} : (jl ? {pst_q, left_len} : {off_q, right_len});
        end
        OP_SRD: raddr = ins_q ? AW'(j_q - 1'b1) : AW'(j_q + 1'b1);
        OP_SWR: begin
          we    = 1'b1;
          waddr = j_q[AW-1:0];
          wdata = rd_q;
        end
        OP_FIN: begin
          we    = ins_q;
          waddr = pos_q[AW-1:0];
          wdata = ins_ent_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_MAX;
      cnt_q  <= '0;
      used_q <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cap_sat;
      cnt_q  <= (cap_sat != '0) ? CW'(1) : '0;
      used_q <= '0;
    end else begin
      unique case (op_i)
        OP_INIT: begin
          cnt_q  <= (cap_q != '0) ? CW'(1) : '0;
          used_q <= '0;
        end
        OP_AEV2: if (fit && !(!pad0 && !post0 && full)) used_q <= used_add;
        OP_RDEC: if (jl || jr || !full) used_q <= used_sub;
        OP_FIN:  cnt_q <= ins_q ? cnt_q + 1'b1 : cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        cmd_q   <= in_cmd_i;
        size_q  <= in_size_i;
        lg_q    <= in_lg_i;
        off_q   <= in_off_i;
        grant_q <= '0;
      end
      OP_CHK: begin
        res_q <= bad ? ST_BAD : ST_OK;
        k_q   <= '0;
      end
      OP_ARD: if (k_q == cnt_q) res_q <= ST_NOFIT;
      OP_AEV1: begin
        st_q  <= rd_st;
        len_q <= rd_len;
        al_q  <= al_w;
        end_q <= end_w;
      end
      OP_AEV2: begin
        if (!fit) begin
          k_q <= k_q + 1'b1;
        end else if (!pad0 && !post0 && full) begin
          res_q <= ST_FULL;
        end else begin
          grant_q   <= al_q[31:0];
          ins_q     <= !pad0;
          j_q       <= pad0 ? k_q : cnt_q;
          pos_q     <= k_q + 1'b1;
          ins_ent_q <= {tail_off[31:0], post_len[32:0]};
        end
      end
      OP_REV: begin
        if (rd_st < off_q) begin
          pst_q  <= rd_st;
          plen_q <= rd_len;
          k_q    <= k_q + 1'b1;
        end else begin
          st_q  <= rd_st;
          len_q <= rd_len;
        end
      end
      OP_RDEC: begin
        if (!jl && !jr && full) res_q <= ST_FULL;
        ins_q     <= !jl;
        j_q       <= jl ? k_q : cnt_q;
        pos_q     <= k_q;
        ins_ent_q <= {off_q, size_q};
      end
      OP_SWR: j_q <= ins_q ? j_q - 1'b1 : j_q + 1'b1;
      OP_LST: begin
        k_q   <= '0;
        max_q <= '0;
      end
      OP_LEV: begin
        if (rd_len > max_q) max_q <= rd_len;
        k_q <= k_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign res_status_o  = res_q;
  assign res_offset_o  = grant_q;
  assign res_used_o    = used_q;
  assign res_largest_o = max_q;

endmodule

/* design/ffra_ctrl.sv */
// controller state machine sequencing scans, shifts and the result beat
module ffra_ctrl import ffra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_CHK;
      S_CHK: begin
        if (status_i.bad) state_d = S_LST;
        else state_d = status_i.is_rel ? S_RRD : S_ARD;
      end
      S_ARD:  state_d = status_i.scan_end ? S_LST : S_AEV1;
      S_AEV1: state_d = S_AEV2;
      S_AEV2: begin
        if (!status_i.fit) state_d = S_ARD;
        else state_d = status_i.shift ? S_SRD : S_LST;
      end
      S_RRD:  state_d = status_i.scan_end ? S_RDEC : S_REV;
      S_REV:  state_d = status_i.lt ? S_RRD : S_RDEC;
      S_RDEC: state_d = status_i.shift ? S_SRD : S_LST;
      S_SRD:  state_d = status_i.shift_done ? S_FIN : S_SWR;
      S_SWR:  state_d = S_SRD;
      S_FIN:  state_d = S_LST;
      S_LST:  state_d = S_LRD;
      S_LRD:  state_d = status_i.scan_end ? S_OUT : S_LEV;
      S_LEV:  state_d = S_LRD;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_INIT: op_o = OP_INIT;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      S_CHK:  op_o = OP_CHK;
      S_ARD:  op_o = OP_ARD;
      S_AEV1: op_o = OP_AEV1;
      S_AEV2: op_o = OP_AEV2;
      S_RRD:  op_o = OP_RRD;
      S_REV:  op_o = OP_REV;
      S_RDEC: op_o = OP_RDEC;
      S_SRD:  op_o = OP_SRD;
      S_SWR:  op_o = OP_SWR;
      S_FIN:  op_o = OP_FIN;
      S_LST:  op_o = OP_LST;
      S_LRD:  op_o = OP_LRD;
      S_LEV:  op_o = OP_LEV;
      S_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

/* design/first_fit_aligned_range_allocator.sv */
// First-fit aligned range allocator. Free ranges sit sorted by offset in a table memory
// of MAX_RANGES entries (one read, one write port); one request is handled at a time.
// An allocation reads and evaluates each entry in turn (ARD, AEV1, AEV2) until one fits,
// a release reads and evaluates entries (RRD, REV) up to its insertion point, each table
// entry moved when a range is inserted or removed is read and then written (SRD, SWR),
// and the largest-free pass reads and evaluates each live entry (LRD, LEV), all paced by
// the single memory read port. After reset the INIT state loads the initial range before
// the first beat is taken; a capacity write rebuilds the table in the same cycle.
module first_fit_aligned_range_allocator import ffra_pkg::*; #(
  parameter int MAX_RANGES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [32:0]  cfg_wdata_i,    // pool_capacity
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // request_size, align_log2, release_offset
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // status, block_offset, used_bytes, largest_free
);

  dp_op_e      op;
  dp_status_t  dp_st;
  logic [1:0]  res_status;
  logic [31:0] res_offset;
  logic [32:0] res_used, res_largest;

  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_st),
    .op_o        (op),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  ffra_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (dp_st),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_cmd_i      (s_axis_tuser),
    .in_size_i     (s_axis_tdata[32:0]),
    .in_lg_i       (s_axis_tdata[37:33]),
    .in_off_i      (s_axis_tdata[69:38]),
    .res_status_o  (res_status),
    .res_offset_o  (res_offset),
    .res_used_o    (res_used),
    .res_largest_o (res_largest)
  );

  assign m_axis_tdata = {4'd0, res_largest, res_used, res_offset, res_status};

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request finished without processing");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)) |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("offset reported on a failed request");
`endif

endmodule

/* verif/tb_first_fit_aligned_range_allocator.sv */
// self-checking testbench for the first-fit aligned range allocator
module tb_first_fit_aligned_range_allocator import ffra_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 64;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [63:0] LIM33 = 64'h1_FFFF_FFFF;

  typedef struct {
    alloc_status_e status;
    logic [31:0]   offset;
    logic [32:0]   used;
    logic [32:0]   largest;
  } alloc_reply_t;

  typedef struct {
    logic [31:0] offset;
    logic [32:0] size;
  } live_block_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [32:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // request_size, align_log2, release_offset
  logic         s_axis_tuser = 1'b0; // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // status, block_offset, used_bytes, largest_free

  first_fit_aligned_range_allocator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // predictor state
  logic [31:0] free_start[TBL_DEPTH];
  logic [32:0] free_len[TBL_DEPTH];
  int          free_count;
  logic [32:0] used_sum;
  logic [32:0] pool_cap;

  alloc_reply_t pending_replies[$];
  live_block_t  live_blocks[$];
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic logic [32:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > LIM33) ? LIM33[32:0] : s[32:0];
  endfunction

  function automatic void pool_rebuild(logic [32:0] v);
    pool_cap = (v > CAP_MAX) ? CAP_MAX : v;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      free_start[k] = '0;
      free_len[k] = '0;
    end
    used_sum = '0;
    free_count = (pool_cap == 0) ? 0 : 1;
    free_len[0] = pool_cap;
  endfunction

  function automatic void drop_range(int pos);
    for (int k = pos; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k+1];
      free_len[k] = free_len[k+1];
    end
    free_count--;
  endfunction

  function automatic void put_range(int pos, logic [31:0] st, logic [32:0] len);
    for (int k = free_count; k > pos; k--) begin
      free_start[k] = free_start[k-1];
      free_len[k] = free_len[k-1];
    end
    free_start[pos] = st;
    free_len[pos] = len;
    free_count++;
  endfunction

  function automatic alloc_reply_t predict_reply(bit cmd, logic [32:0] size, logic [4:0] lg,
                                                 logic [31:0] off);
    alloc_reply_t r;
    logic [63:0] mask, st, len, al, pad, post, plen, fin;
    int pos;
    bit done, jr, jl;
    r.status = ST_NOFIT;
    r.offset = '0;
    done = 0;
    if (!cmd) begin
      mask = (64'd1 << lg) - 64'd1;
      if (size == 0 || size > pool_cap) begin
        r.status = ST_BAD;
      end else begin
        for (int k = 0; k < free_count && !done; k++) begin
          st = 64'(free_start[k]);
          len = 64'(free_len[k]);
          al = (st + mask) & ~mask;
          pad = al - st;
          if (pad >= len || 64'(size) > len - pad) continue;
          done = 1;
          post = al + 64'(size);
          plen = st + len - post;
          if (pad != 0 && plen != 0 && free_count >= TBL_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (pad == 0 && plen == 0) begin
              drop_range(k);
            end else if (pad == 0) begin
              free_start[k] = post[31:0];
              free_len[k] = plen[32:0];
            end else if (plen == 0) begin
              free_len[k] = pad[32:0];
            end else begin
              free_len[k] = pad[32:0];
              put_range(k + 1, post[31:0], plen[32:0]);
            end
            used_sum = add_clamped(64'(used_sum), 64'(size));
            r.status = ST_OK;
            r.offset = al[31:0];
          end
        end
      end
    end else begin
      fin = 64'(off) + 64'(size);
      if (size == 0 || fin > 64'(pool_cap)) begin
        r.status = ST_BAD;
      end else begin
        pos = 0;
        while (pos < free_count && free_start[pos] < off) pos++;
        jr = (pos < free_count) && (fin == 64'(free_start[pos]));
        jl = (pos > 0) && (64'(free_start[pos-1]) + 64'(free_len[pos-1]) == 64'(off));
        if (!jr && !jl && free_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          used_sum = (used_sum > size) ? used_sum - size : '0;
          if (jr && jl) begin
            free_len[pos-1] = add_clamped(64'(add_clamped(64'(free_len[pos-1]), 64'(size))),
                                          64'(free_len[pos]));
            drop_range(pos);
          end else if (jr) begin
            free_start[pos] = off;
            free_len[pos] = add_clamped(64'(free_len[pos]), 64'(size));
          end else if (jl) begin
            free_len[pos-1] = add_clamped(64'(free_len[pos-1]), 64'(size));
          end else begin
            put_range(pos, off, size);
          end
        end
      end
    end
    r.used = used_sum;
    r.largest = '0;
    for (int k = 0; k < free_count; k++)
      if (free_len[k] > r.largest) r.largest = free_len[k];
    return r;
  endfunction

  task automatic send_req(bit cmd, logic [32:0] size, logic [4:0] lg, logic [31:0] off);
    alloc_reply_t r;
    live_block_t  b;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, off, lg, size};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_reply(cmd, size, lg, off);
    pending_replies = {pending_replies, r};
    if (!cmd && r.status == ST_OK) begin
      b.offset = r.offset;
      b.size = size;
      live_blocks = {live_blocks, b};
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [32:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_rebuild(v);
    live_blocks.delete();
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    alloc_reply_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        e = pending_replies.pop_front();
        if (m_axis_tdata[1:0] !== e.status || m_axis_tdata[33:2] !== e.offset ||
            m_axis_tdata[66:34] !== e.used || m_axis_tdata[99:67] !== e.largest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d off=%h used=%h lf=%h got st=%0d off=%h used=%h lf=%h",
                     e.status, e.offset, e.used, e.largest, m_axis_tdata[1:0],
                     m_axis_tdata[33:2], m_axis_tdata[66:34], m_axis_tdata[99:67]);
        end
      end
    end
  end

  task automatic test_directed();
    send_req(1'b0, 33'h1_0000_0000, 5'd0, 32'd0);
    send_req(1'b1, 33'h1_0000_0000, 5'd0, 32'd0);
    send_req(1'b0, 33'd0, 5'd3, 32'd0);
    send_req(1'b1, 33'd0, 5'd0, 32'd5);
    send_req(1'b0, 33'h1_FFFF_FFFF, 5'd0, 32'd0);
    send_req(1'b1, 33'd2, 5'd0, 32'hFFFF_FFFF);
    send_req(1'b0, 33'd100, 5'd31, 32'd0);
    send_req(1'b0, 33'd7, 5'd31, 32'd0);
    send_req(1'b0, 33'h0_FFFF_FFFF, 5'd0, 32'd0);
    send_req(1'b1, 33'd1, 5'd0, 32'hFFFF_FFFF);
    send_req(1'b1, 33'd100, 5'd0, 32'd0);
    send_req(1'b1, 33'd7, 5'd0, 32'h8000_0000);
    drain();
    write_capacity(33'd0);
    send_req(1'b0, 33'd1, 5'd0, 32'd0);
    send_req(1'b1, 33'd1, 5'd0, 32'd0);
    send_req(1'b1, 33'd0, 5'd0, 32'd0);
    write_capacity(33'h1_FFFF_FFFF);
    send_req(1'b0, 33'd4, 5'd2, 32'd0);
    write_capacity(33'd1);
    send_req(1'b0, 33'd1, 5'd0, 32'd0);
    send_req(1'b0, 33'd1, 5'd0, 32'd0);
    send_req(1'b1, 33'd1, 5'd0, 32'd0);
    send_req(1'b0, 33'd1, 5'd1, 32'd0);
    write_capacity(33'd64);
    send_req(1'b0, 33'd8, 5'd4, 32'd0);
    send_req(1'b0, 33'd60, 5'd0, 32'd0);
    send_req(1'b1, 33'd8, 5'd0, 32'd16);
  endtask

  task automatic test_table_full();
    write_capacity(33'd200);
    for (int k = 0; k < 150; k++) send_req(1'b0, 33'd1, 5'd0, 32'd0);
    for (int k = 0; k < 150; k += 2) send_req(1'b1, 33'd1, 5'd0, 32'(k));
    send_req(1'b0, 33'd2, 5'd3, 32'd0);
    send_req(1'b0, 33'd1, 5'd3, 32'd0);
    for (int k = 1; k < 150; k += 2) send_req(1'b1, 33'd1, 5'd0, 32'(k));
  endtask

  task automatic test_random(int n, int idle, int stall);
    logic [32:0] sz, cap;
    logic [4:0] lg;
    logic [31:0] off;
    int pick;
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        pick = $urandom_range(5);
        if (pick == 0) cap = CAP_MAX;
        else if (pick == 1) cap = {1'($urandom_range(1)), $urandom()};
        else cap = 33'($urandom_range(4096, 1));
        write_capacity(cap);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        sz = {1'($urandom_range(1)), $urandom()};
        if ($urandom_range(1)) sz = sz & 33'hFF;
        send_req(1'($urandom_range(1)), sz, 5'($urandom()), $urandom());
      end else if (pick < 50 && live_blocks.size() != 0) begin
        pick = $urandom_range(live_blocks.size() - 1);
        off = live_blocks[pick].offset;
        sz = live_blocks[pick].size;
        live_blocks.delete(pick);
        send_req(1'b1, sz, 5'($urandom()), off);
      end else begin
        if (pool_cap > 33'd4096) sz = 33'($urandom_range(1 << $urandom_range(30), 1));
        else sz = 33'($urandom_range(pool_cap / 8 + 1, 1));
        lg = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(6));
        send_req(1'b0, sz, lg, $urandom());
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pool_rebuild(CAP_MAX);
    test_directed();
    test_table_full();
    test_random(220, 0, 0);
    test_random(220, 85, 0);
    test_random(220, 0, 85);
    test_random(220, 22, 22);
    drain();
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* first_fit_aligned_range_allocator.f */
design/ffra_pkg.sv
design/ffra_dp.sv
design/ffra_ctrl.sv
design/first_fit_aligned_range_allocator.sv
verif/tb_first_fit_aligned_range_allocator.sv
